// ===== design/sus_pkg.sv =====
package sus_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int POS_FIELD_W = 7;

  typedef enum logic [1:0] {
    CMD_LOCATE = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [KEY_FIELD_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [POS_FIELD_W-1:0] position;
    logic                   changed;
    logic                   table_full;
    logic [POS_FIELD_W-1:0] entry_count;
  } out_item_t;

  // comparator verdict: request key against stored entry
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== design/sus_key_ram.sv =====
module sus_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sus_cmp.sv =====
module sus_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [KEY_WIDTH-1:0] entry,
  input  logic                 signed_mode,
  output sus_pkg::cmp_res_t    res
);

  import sus_pkg::*;

  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] key_b;
  logic [KEY_WIDTH-1:0] entry_b;

  // biasing the sign bit turns a signed compare into an unsigned one
  assign sign_flip = {signed_mode, {(KEY_WIDTH-1){1'b0}}};
  assign key_b     = key ^ sign_flip;
  assign entry_b   = entry ^ sign_flip;

  always_comb begin
    res.lt = key_b < entry_b;
    res.eq = key_b == entry_b;
  end

endmodule

// ===== design/sorted_unique_key_set.sv =====
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | in_data   (cmd, key)
// out_    | output    | out_valid / out_ready | out_data  (found, position, changed,
//         |           |                       |            table_full, entry_count)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data  (compare_signed)
//
// one request at a time; each binary-search probe is a ram read (S_PROBE) then a compare
// (S_CMP), up to ceil(log2(count))+1 probes, after accept and before decide and result
// insert moves (count - position) entries up, one ram write each, then writes the key;
// remove moves (count - position - 1) entries down, one ram write per moved entry
// clear needs no search; rst_n (synchronous) empties the set, ram contents are not cleared
// a waiting result does not block the next accept; a finished request waits for the slot
module sorted_unique_key_set #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sus_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sus_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  import sus_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROBE = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_ACT   = 8'b0000_1000,
    S_SHUP  = 8'b0001_0000,
    S_SHDN  = 8'b0010_0000,
    S_INS   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  signed_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]      lo_r, lo_nxt;
  logic [CNT_W-1:0]      hi_r, hi_nxt;
  logic [CNT_W-1:0]      probe_r, probe_nxt;
  logic                  single_r, single_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  logic                  found_r, found_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  changed_r, changed_nxt;
  logic                  full_r, full_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [KEY_WIDTH-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [KEY_WIDTH-1:0]  ram_rdata;
  cmp_res_t              cmp;

  logic [63:0]           key_ext;
  logic [CNT_W:0]        mid_sum;
  logic [CNT_W-1:0]      probe_c;
  logic                  single_c;
  logic [CNT_W+6:0]      pos_wide;
  logic [CNT_W+6:0]      cnt_wide;
  logic                  slot_free;

  sus_key_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(KEY_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // the one comparator that every probe goes through
  sus_cmp #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_cmp (
    .key        (key_r),
    .entry      (ram_rdata),
    .signed_mode(signed_r),
    .res        (cmp)
  );

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  // only the low KEY_WIDTH bits of the key field take part
  assign key_ext = {32'd0, in_data.key};

  // probe index (lo + hi + 1) / 2, or lo when one entry is left
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + {{CNT_W{1'b0}}, 1'b1};
  assign single_c = (hi_r - lo_r) == ONE_C;
  assign probe_c  = single_c ? lo_r : mid_sum[CNT_W:1];

  assign pos_wide = {7'd0, pos_r};
  assign cnt_wide = {7'd0, count_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    probe_nxt     = probe_r;
    single_nxt    = single_r;
    w_nxt         = w_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    changed_nxt   = changed_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = w_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = probe_c[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.cmd;
          key_nxt     = key_ext[KEY_WIDTH-1:0];
          lo_nxt      = '0;
          hi_nxt      = count_r;
          found_nxt   = 1'b0;
          pos_nxt     = '0;
          changed_nxt = 1'b0;
          full_nxt    = 1'b0;
          if (in_data.cmd == CMD_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            // empty set: insert point is zero, nothing to search
            state_nxt = S_ACT;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        // ram read of the probe issued here, data next cycle
        probe_nxt  = probe_c;
        single_nxt = single_c;
        state_nxt  = S_CMP;
      end

      S_CMP: begin
        if (cmp.eq) begin
          found_nxt = 1'b1;
          pos_nxt   = probe_r;
          state_nxt = S_ACT;
        end else if (single_r) begin
          pos_nxt   = cmp.lt ? lo_r : hi_r;
          state_nxt = S_ACT;
        end else begin
          if (cmp.lt) begin
            hi_nxt = probe_r;
          end else begin
            lo_nxt = probe_r;
          end
          state_nxt = S_PROBE;
        end
      end

      S_ACT: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_INSERT && !found_r) begin
          if (count_r >= CAP_C) begin
            full_nxt = 1'b1;
          end else if (pos_r == count_r) begin
            state_nxt = S_INS;
          end else begin
            // move entries up, starting from the top one
            ram_raddr = AW'(count_r - ONE_C);
            w_nxt     = count_r;
            state_nxt = S_SHUP;
          end
        end else if (cmd_r == CMD_REMOVE && found_r) begin
          if (pos_r == count_r - ONE_C) begin
            count_nxt   = count_r - ONE_C;
            changed_nxt = 1'b1;
          end else begin
            // move entries down, starting just above the removed one
            ram_raddr = AW'(pos_r + ONE_C);
            w_nxt     = pos_r;
            state_nxt = S_SHDN;
          end
        end
      end

      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = w_r[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = AW'(w_r - CNT_W'(2));
        if (w_r - ONE_C == pos_r) begin
          state_nxt = S_INS;
        end else begin
          w_nxt = w_r - ONE_C;
        end
      end

      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = w_r[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = AW'(w_r + CNT_W'(2));
        if (w_r + ONE_C == count_r - ONE_C) begin
          count_nxt   = count_r - ONE_C;
          changed_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          w_nxt = w_r + ONE_C;
        end
      end

      S_INS: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r[AW-1:0];
        ram_wdata   = key_r;
        count_nxt   = count_r + ONE_C;
        changed_nxt = 1'b1;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        // hand the transaction to the output register once it is free
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found       = found_r;
          out_nxt.position    = pos_wide[6:0];
          out_nxt.changed     = changed_r;
          out_nxt.table_full  = full_r;
          out_nxt.entry_count = cnt_wide[6:0];
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      signed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        signed_r <= cfg_data;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    probe_r   <= probe_nxt;
    single_r  <= single_nxt;
    w_r       <= w_nxt;
    found_r   <= found_nxt;
    pos_r     <= pos_nxt;
    changed_r <= changed_nxt;
    full_r    <= full_nxt;
    out_r     <= out_nxt;
  end

  // the set never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // an accepted request always leaves idle in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted request did not start");

  // a refused insert neither changes the set nor reports a held key
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> !out_data.changed && !out_data.found)
    else $error("table full result inconsistent");

  // a search that runs always has a non-empty range
  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> lo_r < hi_r)
    else $error("search range empty");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import sus_pkg::*;

  localparam int CAPACITY        = 64;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 8;
  localparam logic [KEY_FIELD_W-1:0] KEY_SIGN_BIT = 32'h8000_0000;

  // request mixes for the random phases
  typedef enum int {MIX_FILL, MIX_SATURATE, MIX_DRAIN, MIX_CHURN} load_mix_t;
  // receiver back-pressure patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_pattern_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  sorted_unique_key_set #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_FIELD_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the key table, used to predict every result
  // ---------------------------------------------------------------------------
  logic [KEY_FIELD_W-1:0] shadow_keys [CAPACITY];
  int                     shadow_count = 0;
  bit                     signed_order = 1'b0;

  // bookkeeping for the run summary
  int n_refused    = 0;
  int n_hits       = 0;
  int peak_count   = 0;
  int n_cfg_writes = 0;
  int n_results    = 0;
  int n_errors     = 0;

  // -1, 0, 1 as a is below, equal to or above b in the current order
  function automatic int key_order(logic [KEY_FIELD_W-1:0] a, logic [KEY_FIELD_W-1:0] b);
    logic [KEY_FIELD_W-1:0] x, y;
    x = a;
    y = b;
    // flipping the sign bit turns two's complement order into unsigned order
    if (signed_order) begin
      x ^= KEY_SIGN_BIT;
      y ^= KEY_SIGN_BIT;
    end
    if (x < y) return -1;
    return (x > y) ? 1 : 0;
  endfunction

  // binary search over [0, count) exactly as the block probes it, so a table
  // left out of order by a mode switch still gives a defined answer
  function automatic bit key_search(logic [KEY_FIELD_W-1:0] key, output int pos);
    int lo, hi, mid, c;
    lo  = 0;
    hi  = shadow_count;
    pos = 0;
    while (lo < hi) begin
      if (hi - lo == 1) begin
        c = key_order(key, shadow_keys[lo]);
        if (c == 0) begin
          pos = lo;
          return 1'b1;
        end
        pos = (c < 0) ? lo : hi;
        return 1'b0;
      end
      mid = (lo + hi + 1) / 2;
      c   = key_order(key, shadow_keys[mid]);
      if (c == 0) begin
        pos = mid;
        return 1'b1;
      end
      if (c > 0) lo = mid;
      else hi = mid;
    end
    pos = lo;
    return 1'b0;
  endfunction

  // applies one request to the shadow table and returns the result it causes
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        pos;
    bit        hit;
    res = '0;
    if (req.cmd == CMD_CLEAR) begin
      // clear reports all zero fields
      shadow_count = 0;
    end else begin
      hit = key_search(req.key, pos);
      res.found    = hit;
      res.position = pos[POS_FIELD_W-1:0];
      if (hit) n_hits++;
      if (req.cmd == CMD_INSERT && !hit) begin
        if (shadow_count >= CAPACITY) begin
          // new key, no room: refused, insert point still reported
          res.table_full = 1'b1;
          n_refused++;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[pos] = req.key;
          shadow_count++;
          res.changed = 1'b1;
        end
      end else if (req.cmd == CMD_REMOVE && hit) begin
        for (int i = pos; i < shadow_count - 1; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_count--;
        res.changed = 1'b1;
      end
    end
    res.entry_count = shadow_count[POS_FIELD_W-1:0];
    if (shadow_count > peak_count) peak_count = shadow_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queues and helpers
  // ---------------------------------------------------------------------------
  in_item_t               pending_reqs[$];
  out_item_t              expected_results[$];
  logic [KEY_FIELD_W-1:0] recent_keys[$];   // keys likely held, for hits

  int in_issued   = 0;   // transactions put on the input channel
  int in_accepted = 0;   // transactions taken by the block
  int cycle_cnt   = 0;

  bit sender_idles = 1'b1;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    n_errors++;
  endtask

  task automatic push_req(cmd_t c, logic [KEY_FIELD_W-1:0] k);
    in_item_t req;
    req.cmd = c;
    req.key = k;
    pending_reqs.push_back(req);
  endtask

  // keys weighted toward zero, all ones and both sides of the sign boundary
  function automatic logic [KEY_FIELD_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return KEY_SIGN_BIT + $urandom_range(0, 15);
      3:       return (KEY_SIGN_BIT - 1) - $urandom_range(0, 15);
      4:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_request(load_mix_t mix);
    int                     roll, ins_pct, loc_pct, rem_pct, idx;
    cmd_t                   c;
    logic [KEY_FIELD_W-1:0] k;
    case (mix)
      MIX_FILL:     begin ins_pct = 75; loc_pct = 15; rem_pct = 10; end
      MIX_SATURATE: begin ins_pct = 85; loc_pct = 10; rem_pct = 5;  end
      MIX_DRAIN:    begin ins_pct = 15; loc_pct = 20; rem_pct = 65; end
      default:      begin ins_pct = 40; loc_pct = 25; rem_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    k    = rand_key();
    if (roll < ins_pct) begin
      c = CMD_INSERT;
      // now and then re-insert a held key
      if (recent_keys.size() > 0 && $urandom_range(0, 4) == 0) begin
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else begin
        recent_keys.push_back(k);
        if (recent_keys.size() > 200) void'(recent_keys.pop_front());
      end
    end else if (roll < ins_pct + loc_pct) begin
      c = CMD_LOCATE;
      if (recent_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end
    end else if (roll < ins_pct + loc_pct + rem_pct) begin
      c = CMD_REMOVE;
      if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, recent_keys.size() - 1);
        k   = recent_keys[idx];
        recent_keys.delete(idx);
      end
    end else begin
      c = CMD_CLEAR;
      recent_keys.delete();
    end
    push_req(c, k);
  endtask

  // waits until the block has nothing in flight
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_accepted != in_issued ||
           expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // single register write, only issued while idle
  task automatic set_compare_mode(bit mode);
    @(negedge clk);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    signed_order = mode;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: bursts of transactions separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    // hold the payload while an offered transaction is still waiting
    if (!(in_valid && in_accepted != in_issued)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = sender_idles ? $urandom_range(1, 12) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: out_ready follows a pattern that changes every so often
  // ---------------------------------------------------------------------------
  rx_pattern_t rx_mode      = RX_OPEN;
  int          rx_mode_left = 0;
  int          rx_hold      = 0;

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_pattern_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ready <= (cycle_cnt % 3 == 0);
        default: begin
          // mostly ready, with an occasional long stall
          if ($urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(4, 30);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results first, then predicts newly accepted requests
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %p", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found)
            report_mismatch($sformatf("found got %b want %b", out_data.found, want.found));
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      out_data.position, want.position));
          if (out_data.changed !== want.changed)
            report_mismatch($sformatf("changed got %b want %b",
                                      out_data.changed, want.changed));
          if (out_data.table_full !== want.table_full)
            report_mismatch($sformatf("table_full got %b want %b",
                                      out_data.table_full, want.table_full));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_data.entry_count, want.entry_count));
        end
      end
      // a transaction accepted at this edge
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
        in_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    load_mix_t mix;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unsigned order: empty table, extremes, duplicates, absent keys, clear
    set_compare_mode(1'b0);
    push_req(CMD_LOCATE, 32'h0000_0000);
    push_req(CMD_REMOVE, 32'h0000_0000);
    push_req(CMD_INSERT, 32'hFFFF_FFFF);
    push_req(CMD_INSERT, 32'h0000_0000);
    push_req(CMD_INSERT, 32'h8000_0000);
    push_req(CMD_INSERT, 32'h7FFF_FFFF);
    push_req(CMD_INSERT, 32'h0000_0001);
    push_req(CMD_INSERT, 32'hFFFF_FFFF);   // already held
    push_req(CMD_LOCATE, 32'h7FFF_FFFF);
    push_req(CMD_LOCATE, 32'h1234_5678);   // absent
    push_req(CMD_REMOVE, 32'h5555_5555);   // absent
    push_req(CMD_REMOVE, 32'h0000_0000);
    push_req(CMD_LOCATE, 32'hAAAA_AAAA);
    push_req(CMD_CLEAR,  32'hFFFF_FFFF);
    push_req(CMD_LOCATE, 32'h8000_0000);
    push_req(CMD_INSERT, 32'hAAAA_AAAA);
    push_req(CMD_INSERT, 32'h5555_5555);
    settle();

    // switch to signed while keys are held: table now out of order
    set_compare_mode(1'b1);
    push_req(CMD_LOCATE, 32'hAAAA_AAAA);
    push_req(CMD_INSERT, 32'h8000_0000);
    push_req(CMD_INSERT, 32'h7FFF_FFFF);
    push_req(CMD_LOCATE, 32'hFFFF_FFFF);
    push_req(CMD_REMOVE, 32'h5555_5555);
    settle();

    // random phases; fill, saturate, drain and churn in both orders
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_compare_mode(p[0] ^ p[2]);
      sender_idles = (p != 3);
      mix = load_mix_t'(p % 4);
      repeat (ITEMS_PER_PHASE) gen_request(mix);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d results, %0d mode writes",
             in_accepted, n_results, n_cfg_writes);
    $display("key hits %0d, refused inserts %0d, peak occupancy %0d of %0d",
             n_hits, n_refused, peak_count, CAPACITY);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
